// ===== rtl/cglc_pkg.sv =====
package cglc_pkg;

    // Grid geometry and string limits
    localparam int ROWS    = 32;
    localparam int COLS    = 64;
    localparam int MAX_LEN = 1024;
    localparam int GRID_N  = ROWS * COLS;
    localparam int ADDR_W  = $clog2(GRID_N);
    localparam int POS_W   = $clog2(MAX_LEN);
    localparam int ERRP_W  = 10;

    // Characters the parser recognizes
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Status codes
    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_SYNTAX = 2'd1;
    localparam logic [1:0] STS_BOUNDS = 2'd2;

    typedef enum logic [2:0] {
        PH_CMD,
        PH_SIGN,
        PH_DIGIT1,
        PH_DIGIT2,
        PH_PEN,
        PH_DEAD
    } phase_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_FEED,
        ST_LETTER,
        ST_LINE_RD,
        ST_LINE_WR,
        ST_CLEAR,
        ST_FIN,
        ST_RDWAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       action;
        logic [7:0] ch;
        logic       last;
        logic [7:0] row;
        logic [7:0] col;
    } item_t;

    // Back to front queue control
    typedef struct packed {
        logic pop;
        logic hold;
    } q_ctrl_t;

endpackage

// ===== rtl/char_grid_line_command_engine.sv =====
// Character grid line command engine. Command bytes and cell reads enter on the cmd
// channel through a two-entry queue; results leave on the rsp channel from an output
// register. After reset the grid is swept to spaces, one cell a cycle over all
// ROWS*COLS (2048) cells, and no transaction is accepted until the sweep ends. One
// sequencer executes transactions in order: the last byte of a string also yields
// its status, a line reads then writes each cell drawn in the grid memory (up to
// 64 cells), and a C command runs a full sweep of the grid memory.
module char_grid_line_command_engine
    import cglc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  logic              action,
    input  logic [7:0]        char_in,
    input  logic              last_char,
    input  logic [7:0]        read_row,
    input  logic [7:0]        read_col,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic              is_read_reply,
    output logic [1:0]        status,
    output logic [ERRP_W-1:0] error_position,
    output logic [6:0]        cell_char
);

    q_ctrl_t ctrl;
    logic    q_valid;
    item_t   q_item;

    // Front: accepts and queues transactions
    cglc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .action    (action),
        .char_in   (char_in),
        .last_char (last_char),
        .read_row  (read_row),
        .read_col  (read_col),
        .ctrl      (ctrl),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // Back: parses, draws and replies
    cglc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .ctrl           (ctrl),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .is_read_reply  (is_read_reply),
        .status         (status),
        .error_position (error_position),
        .cell_char      (cell_char)
    );

endmodule

// ===== rtl/cglc_front.sv =====
module cglc_front
    import cglc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic       action,
    input  logic [7:0] char_in,
    input  logic       last_char,
    input  logic [7:0] read_row,
    input  logic [7:0] read_col,
    input  q_ctrl_t    ctrl,
    output logic       q_valid,
    output item_t      q_item
);

    item_t      q_mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    // Accept when there is room and the back is not sweeping after reset
    assign cmd_stall = (count_reg == 2'd2) || ctrl.hold;
    assign push      = cmd_valid && !cmd_stall;
    assign pop       = ctrl.pop && (count_reg != 2'd0);
    assign q_valid   = (count_reg != 2'd0);
    assign q_item    = q_mem_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= '{action: action, ch: char_in, last: last_char,
                                       row: read_row, col: read_col};
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== rtl/cglc_back.sv =====
module cglc_back
    import cglc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  item_t             q_item,
    output q_ctrl_t           ctrl,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic              is_read_reply,
    output logic [1:0]        status,
    output logic [ERRP_W-1:0] error_position,
    output logic [6:0]        cell_char
);

    state_t state_reg, state_next;

    // Parser and pen state
    logic [7:0]       cur_row_reg, cur_row_next;
    logic [7:0]       cur_col_reg, cur_col_next;
    logic [6:0]       pen_reg, pen_next;
    logic             mode_reg, mode_next;
    phase_t           phase_reg, phase_next;
    logic             dir_reg, dir_next;
    logic             neg_reg, neg_next;
    logic [3:0]       fdig_reg, fdig_next;
    logic [POS_W-1:0] cstart_reg, cstart_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       err_st_reg, err_st_next;
    logic [POS_W-1:0] err_at_reg, err_at_next;

    // Current transaction
    item_t            it_reg, it_next;
    logic [POS_W-1:0] it_pos_reg, it_pos_next;

    // Line and sweep sequencing
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic [7:0]        end_reg, end_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;

    // Result register
    logic              rv_reg, rv_next;
    logic              rr_reg, rr_next;
    logic [1:0]        rs_reg, rs_next;
    logic [ERRP_W-1:0] rp_reg, rp_next;
    logic [6:0]        rc_reg, rc_next;

    // Grid memory
    logic [6:0]        grid_mem [GRID_N];
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [6:0]        wr_data, rd_data_reg;

    // Character decode of the current byte
    logic [7:0] ch, lower;
    logic       is_dig, is_prt, is_minus;
    logic       let_c, let_hv, let_fb;
    logic [3:0] dig;

    assign ch       = it_reg.ch;
    assign lower    = (ch inside {[8'h41:8'h5A]}) ? ch + 8'd32 : ch;
    assign is_dig   = ch inside {[8'h30:8'h39]};
    assign is_prt   = ch inside {[8'h20:8'h7E]};
    assign is_minus = (ch == CH_MINUS);
    assign dig      = ch[3:0];
    assign let_c    = (lower == CH_C);
    assign let_hv   = (lower == CH_H) || (lower == CH_V);
    assign let_fb   = (lower == CH_F) || (lower == CH_B);

    // Line length and bounds check
    logic [6:0]        mag;
    logic [7:0]        cur_sel;
    logic signed [9:0] cur_s, mag_s, end_s, lim_s;
    logic              line_ok;
    logic [ADDR_W-1:0] start_addr, step_amt;
    logic [6:0]        row0, col0;

    assign mag = (state_reg == ST_FEED && is_dig) ? 7'(fdig_reg) * 7'd10 + 7'(dig)
                                                  : 7'(fdig_reg);
    assign cur_sel    = dir_reg ? cur_row_reg : cur_col_reg;
    assign cur_s      = $signed({2'b00, cur_sel});
    assign mag_s      = $signed({3'b000, mag});
    assign end_s      = neg_reg ? cur_s - mag_s : cur_s + mag_s;
    assign lim_s      = dir_reg ? $signed(10'(ROWS)) : $signed(10'(COLS));
    assign line_ok    = (end_s >= 10'sd1) && (end_s <= lim_s);
    assign row0       = 7'(cur_row_reg - 8'd1);
    assign col0       = 7'(cur_col_reg - 8'd1);
    assign start_addr = ADDR_W'(32'(row0) * COLS) + ADDR_W'(col0);
    assign step_amt   = dir_reg ? ADDR_W'(COLS) : ADDR_W'(1);

    // Read request address and range
    logic              rd_in_grid;
    logic [6:0]        q_row0, q_col0;
    logic [ADDR_W-1:0] q_addr;

    assign rd_in_grid = (it_reg.row >= 8'd1) && (32'(it_reg.row) <= ROWS)
                     && (it_reg.col >= 8'd1) && (32'(it_reg.col) <= COLS);
    assign q_row0     = 7'(q_item.row - 8'd1);
    assign q_col0     = 7'(q_item.col - 8'd1);
    assign q_addr     = ADDR_W'(32'(q_row0) * COLS) + ADDR_W'(q_col0);

    logic out_free;
    assign out_free = !rv_reg || !rsp_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
                if (clr_reg == ADDR_W'(GRID_N - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (q_valid)
                    state_next = q_item.action ? ST_RDWAIT : ST_FEED;
            ST_FEED:
                case (phase_reg)
                    PH_CMD:
                        state_next = let_c ? ST_CLEAR : ST_FIN;
                    PH_DIGIT2:
                        state_next = line_ok ? ST_LINE_RD : ST_FIN;
                    default:
                        state_next = ST_FIN;
                endcase
            ST_LETTER:
                state_next = let_c ? ST_CLEAR : ST_FIN;
            ST_LINE_RD:
                state_next = ST_LINE_WR;
            ST_LINE_WR:
                if (cnt_reg == 7'd0)
                    state_next = pend_reg ? ST_LETTER : ST_FIN;
                else
                    state_next = ST_LINE_RD;
            ST_CLEAR:
                if (clr_reg == ADDR_W'(GRID_N - 1))
                    state_next = ST_FIN;
            ST_FIN:
                if (!it_reg.last)
                    state_next = ST_IDLE;
                else if (phase_reg == PH_DIGIT2)
                    state_next = line_ok ? ST_LINE_RD : ST_FIN;
                else if (phase_reg == PH_CMD || phase_reg == PH_DEAD)
                    state_next = ST_EMIT;
                else
                    state_next = ST_FIN;
            ST_RDWAIT:
                state_next = ST_EMIT;
            ST_EMIT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_INIT;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        pen_next     = pen_reg;
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        dir_next     = dir_reg;
        neg_next     = neg_reg;
        fdig_next    = fdig_reg;
        cstart_next  = cstart_reg;
        pos_next     = pos_reg;
        err_st_next  = err_st_reg;
        err_at_next  = err_at_reg;
        it_next      = it_reg;
        it_pos_next  = it_pos_reg;
        addr_next    = addr_reg;
        cnt_next     = cnt_reg;
        end_next     = end_reg;
        pend_next    = pend_reg;
        clr_next     = clr_reg;
        rv_next      = rv_reg && rsp_stall;
        rr_next      = rr_reg;
        rs_next      = rs_reg;
        rp_next      = rp_reg;
        rc_next      = rc_reg;
        wr_en        = 1'b0;
        wr_addr      = addr_reg;
        wr_data      = pen_reg;
        rd_en        = 1'b0;
        rd_addr      = addr_reg;
        ctrl.pop     = 1'b0;
        ctrl.hold    = (state_reg == ST_INIT);

        case (state_reg)
            // Sweep the grid to spaces
            ST_INIT, ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = CH_SPACE[6:0];
                clr_next = clr_reg + ADDR_W'(1);
            end

            // Take the next transaction from the queue
            ST_IDLE:
                if (q_valid)
                begin
                    ctrl.pop = 1'b1;
                    it_next  = q_item;
                    if (q_item.action)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = q_addr;
                    end
                    else
                    begin
                        it_pos_next = pos_reg;
                        if (32'(pos_reg) < MAX_LEN - 1)
                            pos_next = pos_reg + POS_W'(1);
                    end
                end

            ST_FEED, ST_LETTER:
                if (state_reg == ST_LETTER || phase_reg == PH_CMD)
                begin
                    // Command letter
                    if (let_c)
                    begin
                        cur_row_next = 8'd1;
                        cur_col_next = 8'd1;
                        pen_next     = CH_STAR[6:0];
                        mode_next    = 1'b1;
                        clr_next     = '0;
                    end
                    else if (let_hv)
                    begin
                        dir_next    = (lower == CH_V);
                        neg_next    = 1'b0;
                        fdig_next   = 4'd0;
                        cstart_next = it_pos_reg;
                        phase_next  = PH_SIGN;
                    end
                    else if (let_fb)
                    begin
                        mode_next  = (lower == CH_F);
                        phase_next = PH_PEN;
                    end
                    else
                    begin
                        err_st_next = STS_SYNTAX;
                        err_at_next = it_pos_reg;
                        phase_next  = PH_DEAD;
                    end
                end
                else
                begin
                    case (phase_reg)
                        PH_SIGN, PH_DIGIT1:
                            if (phase_reg == PH_SIGN && is_minus)
                            begin
                                neg_next   = 1'b1;
                                phase_next = PH_DIGIT1;
                            end
                            else if (is_dig)
                            begin
                                fdig_next  = dig;
                                phase_next = PH_DIGIT2;
                            end
                            else
                            begin
                                err_st_next = STS_SYNTAX;
                                err_at_next = it_pos_reg;
                                phase_next  = PH_DEAD;
                            end
                        PH_DIGIT2:
                            if (line_ok)
                            begin
                                addr_next = start_addr;
                                cnt_next  = mag;
                                end_next  = end_s[7:0];
                                pend_next = !is_dig;
                            end
                            else
                            begin
                                err_st_next = STS_BOUNDS;
                                err_at_next = cstart_reg;
                                phase_next  = PH_DEAD;
                            end
                        PH_PEN:
                            if (is_prt)
                            begin
                                pen_next   = ch[6:0];
                                phase_next = PH_CMD;
                            end
                            else
                            begin
                                err_st_next = STS_SYNTAX;
                                err_at_next = it_pos_reg;
                                phase_next  = PH_DEAD;
                            end
                        default:
                        begin
                        end
                    endcase
                end

            // Fetch the cell for the background test
            ST_LINE_RD:
                rd_en = 1'b1;

            // Paint the cell and step along the line
            ST_LINE_WR:
            begin
                wr_en = mode_reg || (rd_data_reg == CH_SPACE[6:0]);
                if (cnt_reg == 7'd0)
                begin
                    if (dir_reg)
                        cur_row_next = end_reg;
                    else
                        cur_col_next = end_reg;
                    phase_next = PH_CMD;
                end
                else
                begin
                    cnt_next  = cnt_reg - 7'd1;
                    addr_next = neg_reg ? addr_reg - step_amt : addr_reg + step_amt;
                end
            end

            // End-of-string handling
            ST_FIN:
                if (it_reg.last)
                begin
                    if (phase_reg == PH_DIGIT2)
                    begin
                        if (line_ok)
                        begin
                            addr_next = start_addr;
                            cnt_next  = mag;
                            end_next  = end_s[7:0];
                            pend_next = 1'b0;
                        end
                        else
                        begin
                            err_st_next = STS_BOUNDS;
                            err_at_next = cstart_reg;
                            phase_next  = PH_DEAD;
                        end
                    end
                    else if (phase_reg != PH_CMD && phase_reg != PH_DEAD)
                    begin
                        err_st_next = STS_SYNTAX;
                        err_at_next = pos_reg;
                        phase_next  = PH_DEAD;
                    end
                end

            // Load the result register
            ST_EMIT:
                if (out_free)
                begin
                    rv_next = 1'b1;
                    rr_next = it_reg.action;
                    if (it_reg.action)
                    begin
                        rs_next = STS_OK;
                        rp_next = '0;
                        rc_next = rd_in_grid ? rd_data_reg : CH_SPACE[6:0];
                    end
                    else
                    begin
                        rs_next      = err_st_reg;
                        rp_next      = (err_st_reg != STS_OK) ? ERRP_W'(err_at_reg) : '0;
                        rc_next      = 7'd0;
                        cur_row_next = 8'd1;
                        cur_col_next = 8'd1;
                        phase_next   = PH_CMD;
                        dir_next     = 1'b0;
                        neg_next     = 1'b0;
                        fdig_next    = 4'd0;
                        cstart_next  = '0;
                        pos_next     = '0;
                        err_st_next  = STS_OK;
                        err_at_next  = '0;
                    end
                end

            default:
            begin
            end
        endcase
    end

    // Grid memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            grid_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= grid_mem[rd_addr];
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            cur_row_reg <= 8'd1;
            cur_col_reg <= 8'd1;
            pen_reg     <= CH_STAR[6:0];
            mode_reg    <= 1'b1;
            phase_reg   <= PH_CMD;
            dir_reg     <= 1'b0;
            neg_reg     <= 1'b0;
            fdig_reg    <= 4'd0;
            cstart_reg  <= '0;
            pos_reg     <= '0;
            err_st_reg  <= STS_OK;
            err_at_reg  <= '0;
            cnt_reg     <= 7'd0;
            pend_reg    <= 1'b0;
            clr_reg     <= '0;
            rv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            pen_reg     <= pen_next;
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            dir_reg     <= dir_next;
            neg_reg     <= neg_next;
            fdig_reg    <= fdig_next;
            cstart_reg  <= cstart_next;
            pos_reg     <= pos_next;
            err_st_reg  <= err_st_next;
            err_at_reg  <= err_at_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            clr_reg     <= clr_next;
            rv_reg      <= rv_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        it_reg     <= it_next;
        it_pos_reg <= it_pos_next;
        addr_reg   <= addr_next;
        end_reg    <= end_next;
        rr_reg     <= rr_next;
        rs_reg     <= rs_next;
        rp_reg     <= rp_next;
        rc_reg     <= rc_next;
    end

    assign rsp_valid      = rv_reg;
    assign is_read_reply  = rr_reg;
    assign status         = rs_reg;
    assign error_position = rp_reg;
    assign cell_char      = rc_reg;

endmodule

// ===== dv/char_grid_line_command_engine_tb.sv =====
`timescale 1ns / 100ps

module char_grid_line_command_engine_tb;
    import cglc_pkg::*;

    // Expected response record
    typedef struct {
        logic       is_read;
        logic [1:0] sts;
        logic [9:0] pos;
        logic [6:0] cell_ch;
    } reply_t;

    // Parser state of the predictor
    typedef enum int {
        P_CMD,
        P_SIGN,
        P_DIGIT1,
        P_DIGIT2,
        P_PEN,
        P_DEAD
    } pphase_t;

    // Scoreboard: shadow grid engine plus queue of pending replies
    class grid_scoreboard;
        logic [6:0] cells [ROWS*COLS];
        int         cur_r;
        int         cur_c;
        logic [6:0] pen;
        bit         fg;
        pphase_t    ph;
        bit         vert;
        bit         neg;
        int         dig1;
        int         cmd_pos;
        int         char_pos;
        logic [1:0] err_sts;
        int         err_pos;
        reply_t     pending [$];
        int         mismatches;
        int         reads_seen;
        int         strings_seen;
        int         errors_seen;

        function new();
            wipe();
            fresh_string();
            mismatches = 0;
            reads_seen = 0;
            strings_seen = 0;
            errors_seen = 0;
        endfunction

        function void wipe();
            foreach (cells[i])
                cells[i] = 7'(CH_SPACE);
            cur_r = 1;
            cur_c = 1;
            pen = 7'(CH_STAR);
            fg = 1'b1;
        endfunction

        function void fresh_string();
            cur_r = 1;
            cur_c = 1;
            ph = P_CMD;
            vert = 1'b0;
            neg = 1'b0;
            dig1 = 0;
            cmd_pos = 0;
            char_pos = 0;
            err_sts = STS_OK;
            err_pos = 0;
        endfunction

        function void abort(logic [1:0] code, int p);
            err_sts = code;
            err_pos = p;
            ph = P_DEAD;
        endfunction

        // Bounds check, draw, move cursor
        function bit draw(int mag);
            int dist_v;
            int fin;
            int lim;
            int n;
            int stp;
            int rr;
            int cc;
            dist_v = neg ? -mag : mag;
            fin = vert ? cur_r + dist_v : cur_c + dist_v;
            lim = vert ? ROWS : COLS;
            if (fin < 1 || fin > lim)
            begin
                abort(STS_BOUNDS, cmd_pos);
                return 1'b0;
            end
            n = dist_v < 0 ? -dist_v : dist_v;
            stp = dist_v < 0 ? -1 : 1;
            for (int k = 0; k <= n; k++)
            begin
                rr = vert ? cur_r + k * stp : cur_r;
                cc = vert ? cur_c : cur_c + k * stp;
                if (fg || cells[(rr-1)*COLS + cc-1] == 7'(CH_SPACE))
                    cells[(rr-1)*COLS + cc-1] = pen;
            end
            if (vert)
                cur_r = fin;
            else
                cur_c = fin;
            ph = P_CMD;
            return 1'b1;
        endfunction

        function void letter(logic [7:0] ch, int p);
            logic [7:0] l;
            l = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
            if (l == CH_C)
                wipe();
            else if (l == CH_H || l == CH_V)
            begin
                vert = (l == CH_V);
                neg = 1'b0;
                dig1 = 0;
                cmd_pos = p;
                ph = P_SIGN;
            end
            else if (l == CH_F || l == CH_B)
            begin
                fg = (l == CH_F);
                ph = P_PEN;
            end
            else
                abort(STS_SYNTAX, p);
        endfunction

        function void parse(logic [7:0] ch, int p);
            bit dg;
            dg = ch >= "0" && ch <= "9";
            case (ph)
                P_CMD: letter(ch, p);
                P_SIGN, P_DIGIT1:
                begin
                    if (ph == P_SIGN && ch == CH_MINUS)
                    begin
                        neg = 1'b1;
                        ph = P_DIGIT1;
                    end
                    else if (dg)
                    begin
                        dig1 = ch - "0";
                        ph = P_DIGIT2;
                    end
                    else
                        abort(STS_SYNTAX, p);
                end
                P_DIGIT2:
                begin
                    if (dg)
                        void'(draw(dig1 * 10 + (ch - "0")));
                    else if (draw(dig1))
                        letter(ch, p);
                end
                P_PEN:
                begin
                    if (ch >= 8'h20 && ch <= 8'h7E)
                    begin
                        pen = ch[6:0];
                        ph = P_CMD;
                    end
                    else
                        abort(STS_SYNTAX, p);
                end
                default: ;
            endcase
        endfunction

        // Note one accepted input transaction
        function void note_input(logic act, logic [7:0] ch, logic lst,
                                 logic [7:0] row, logic [7:0] col);
            reply_t e;
            if (act)
            begin
                e.is_read = 1'b1;
                e.sts = STS_OK;
                e.pos = '0;
                e.cell_ch = 7'(CH_SPACE);
                if (row >= 1 && row <= ROWS && col >= 1 && col <= COLS)
                    e.cell_ch = cells[(row-1)*COLS + col-1];
                pending.push_back(e);
                reads_seen++;
                return;
            end
            if (ph != P_DEAD)
                parse(ch, char_pos);
            if (char_pos < MAX_LEN - 1)
                char_pos++;
            if (!lst)
                return;
            if (ph == P_DIGIT2)
                void'(draw(dig1));
            else if (ph != P_CMD && ph != P_DEAD)
                abort(STS_SYNTAX, char_pos);
            e.is_read = 1'b0;
            e.sts = err_sts;
            e.pos = err_sts != STS_OK ? 10'(err_pos) : 10'd0;
            e.cell_ch = '0;
            pending.push_back(e);
            strings_seen++;
            if (err_sts != STS_OK)
                errors_seen++;
            fresh_string();
        endfunction

        // Check one accepted result transaction
        function void check_reply(logic rd, logic [1:0] sts, logic [9:0] pos,
                                  logic [6:0] cell_ch);
            reply_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction: is_read_reply=%0d status=%0d", rd, sts);
                mismatches++;
                return;
            end
            e = pending.pop_front();
            if (rd !== e.is_read)
            begin
                $error("is_read_reply: expected %0d, actual %0d", e.is_read, rd);
                mismatches++;
            end
            if (sts !== e.sts)
            begin
                $error("status: expected %0d, actual %0d", e.sts, sts);
                mismatches++;
            end
            if (pos !== e.pos)
            begin
                $error("error_position: expected %0d, actual %0d", e.pos, pos);
                mismatches++;
            end
            if (cell_ch !== e.cell_ch)
            begin
                $error("cell_char: expected %0d, actual %0d", e.cell_ch, cell_ch);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_stall;
    logic              action;
    logic [7:0]        char_in;
    logic              last_char;
    logic [7:0]        read_row;
    logic [7:0]        read_col;
    logic              rsp_valid;
    logic              rsp_stall;
    logic              is_read_reply;
    logic [1:0]        status;
    logic [ERRP_W-1:0] error_position;
    logic [6:0]        cell_char;

    grid_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  items_sent;

    char_grid_line_command_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .action         (action),
        .char_in        (char_in),
        .last_char      (last_char),
        .read_row       (read_row),
        .read_col       (read_col),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .is_read_reply  (is_read_reply),
        .status         (status),
        .error_position (error_position),
        .cell_char      (cell_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stall, plus a long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b1;
        else
            rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_reply(is_read_reply, status, error_position, cell_char);
    end

    // Offer one transaction, with optional idle cycles first
    task automatic send(logic act, logic [7:0] ch, logic lst, logic [7:0] row, logic [7:0] col);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        action    <= act;
        char_in   <= ch;
        last_char <= lst;
        read_row  <= row;
        read_col  <= col;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.note_input(act, ch, lst, row, col);
        items_sent++;
    endtask

    // Send a whole command string
    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++)
            send(1'b0, s[i], i == s.len() - 1, 8'($urandom), 8'($urandom));
    endtask

    task automatic read_cell(int row, int col);
        send(1'b1, 8'($urandom), 1'($urandom), 8'(row), 8'(col));
    endtask

    // Sender idles until every expected result has come
    task automatic drain();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
    endtask

    // One random token: mostly well-formed commands
    function automatic string rand_token();
        string t;
        int k;
        k = $urandom_range(99);
        if (k < 55)
        begin
            t = $urandom_range(1) ? "h" : "V";
            if ($urandom_range(1)) t = ($urandom_range(1) ? "v" : "H");
            if ($urandom_range(2) == 0) t = {t, "-"};
            t = {t, string'(8'("0" + $urandom_range(9)))};
            if ($urandom_range(2) != 0) t = {t, string'(8'("0" + $urandom_range(2)))};
        end
        else if (k < 80)
        begin
            t = $urandom_range(1) ? "f" : "B";
            if ($urandom_range(1)) t = $urandom_range(1) ? "F" : "b";
            t = {t, string'(8'($urandom_range(8'h20, 8'h7E)))};
        end
        else if (k < 83)
            t = $urandom_range(1) ? "c" : "C";
        else
            t = string'(8'($urandom_range(1, 255)));
        return t;
    endfunction

    // Random phase: strings of tokens interleaved with reads
    task automatic random_phase(int n_items);
        string s;
        int    stop;
        stop = items_sent + n_items;
        while (items_sent < stop)
        begin
            if ($urandom_range(3) == 0)
                read_cell($urandom_range(0, ROWS + 2), $urandom_range(0, COLS + 2));
            else
            begin
                s = "";
                repeat ($urandom_range(1, 5))
                    s = {s, rand_token()};
                if ($urandom_range(19) == 0)
                    send(1'b0, 8'h00, 1'b1, 8'($urandom), 8'($urandom));
                else
                    send_string(s);
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cmd_valid <= 1'b0;
        action <= 1'b0;
        char_in <= '0;
        last_char <= 1'b0;
        read_row <= '0;
        read_col <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        items_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every command, sign, bounds, syntax, read extremes
        send_string("h10v-0B#h-5F");
        send_string("FxH63");
        send_string("v31h-63v-31");
        read_cell(1, 1);
        read_cell(ROWS, COLS);
        read_cell(0, 255);
        read_cell(128, 128);
        send_string("h64");
        send_string("hq");
        send_string("h-");
        send_string("b");
        send(1'b0, 8'hFF, 1'b1, 8'hFF, 8'hFF);
        send_string("c");
        read_cell(1, 11);
        drain();

        // Long string ending in a syntax error
        for (int i = 0; i < 40; i++)
            send(1'b0, "F", 1'b0, '0, '0);
        send(1'b0, 8'h80, 1'b1, '0, '0);

        // Receiver holds off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                random_phase(30);
                drain();
            end
        join

        random_phase(260);
        send_idle_pct = 56;
        random_phase(240);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 56;
        random_phase(240);
        send_idle_pct = 34;
        recv_stall_pct = 34;
        random_phase(220);
        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d transactions: %0d strings (%0d with errors), %0d cell reads",
                 items_sent, sb.strings_seen, sb.errors_seen, sb.reads_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #200ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
